>>> design/ccc_pkg.sv
package ccc_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int RAD_BITS   = 16;
    localparam int NORM_BITS  = 16;
    localparam int PEN_BITS   = 17;
    localparam int RSUM_BITS  = RAD_BITS + 1;
    localparam int D2_BITS    = 2 * RSUM_BITS + 1;
    localparam int RAD2_BITS  = D2_BITS + 28;
    localparam int Q_BITS     = (RAD2_BITS + 1) / 2;
    localparam int DIV_BITS   = 15;
    localparam int NUM_BITS   = RSUM_BITS + 29;
    localparam int NORM_ONE   = 16384;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] centre_a_x;
        logic signed [COORD_BITS-1:0] centre_a_y;
        logic        [RAD_BITS-1:0]   radius_a;
        logic signed [COORD_BITS-1:0] centre_b_x;
        logic signed [COORD_BITS-1:0] centre_b_y;
        logic        [RAD_BITS-1:0]   radius_b;
    } t_in;

    typedef struct packed {
        logic                         hit;
        logic signed [NORM_BITS-1:0]  normal_x;
        logic signed [NORM_BITS-1:0]  normal_y;
        logic signed [COORD_BITS-1:0] contact_x;
        logic signed [COORD_BITS-1:0] contact_y;
        logic        [PEN_BITS-1:0]   penetration;
    } t_out;

    // Per-item side data that rides beside the sqrt and divide pipes.
    typedef struct packed {
        logic                         hit;
        logic                         sx;
        logic                         sy;
        logic        [RSUM_BITS-1:0]  adx;
        logic        [RSUM_BITS-1:0]  ady;
        logic        [RSUM_BITS-1:0]  rsum;
        logic        [RAD_BITS-1:0]   ra;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
    } t_side;

endpackage

>>> design/ccc_sqrt.sv
// Restoring square root, one result bit per stage.
module ccc_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ccc_pkg::RAD2_BITS-1:0] i_n,
    input  ccc_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [ccc_pkg::Q_BITS-1:0]    o_q,
    output ccc_pkg::t_side                o_side
);
    localparam int N = ccc_pkg::Q_BITS;
    localparam int W = 2 * N;

    logic [N:0]               r_v;
    logic [N:0][W-1:0]        r_rem;
    logic [N:0][W-1:0]        r_num;
    logic [N:0][N-1:0]        r_q;
    ccc_pkg::t_side [N:0]     r_side;

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_num[0]  = W'(i_n);
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [W-1:0] n_rem;
        logic [W-1:0] n_trial;
        logic         n_ok;
        always_comb begin
            n_rem   = {r_rem[k][W-3:0], r_num[k][W-1:W-2]};
            n_trial = W'({r_q[k], 2'b01});
            n_ok    = n_rem >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else          r_v[k+1] <= r_v[k];
            r_rem[k+1]  <= n_ok ? n_rem - n_trial : n_rem;
            r_num[k+1]  <= {r_num[k][W-3:0], 2'b00};
            r_q[k+1]    <= {r_q[k][N-2:0], n_ok};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_v[N];
    assign o_q     = r_q[N];
    assign o_side  = r_side[N];
endmodule

>>> design/ccc_div.sv
// Restoring divider for both normal components, one quotient bit per stage.
module ccc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ccc_pkg::Q_BITS-1:0]    i_q,
    input  ccc_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [ccc_pkg::DIV_BITS-1:0]  o_nx,
    output logic [ccc_pkg::DIV_BITS-1:0]  o_ny,
    output logic [ccc_pkg::Q_BITS-1:0]    o_q,
    output ccc_pkg::t_side                o_side
);
    localparam int N  = ccc_pkg::DIV_BITS;
    localparam int QW = ccc_pkg::Q_BITS;
    localparam int RW = ccc_pkg::Q_BITS + 1;
    localparam int NW = ccc_pkg::NUM_BITS;

    // Quotient is clipped at NORM_ONE, so a remainder that already holds
    // the divisor times 2^15 marks overflow; flag it and saturate.
    logic [N:0]            r_v;
    logic [N:0]            r_ovx, r_ovy;
    logic [N:0][NW-1:0]    r_rx, r_ry;
    logic [N:0][N-1:0]     r_qx, r_qy;
    logic [N:0][QW-1:0]    r_d;
    ccc_pkg::t_side [N:0]  r_side;

    logic [NW+QW-1:0] n_nx0, n_ny0, n_lim;
    always_comb begin
        n_nx0 = (NW+QW)'({i_side.adx, 28'd0}) + (NW+QW)'(i_q >> 1);
        n_ny0 = (NW+QW)'({i_side.ady, 28'd0}) + (NW+QW)'(i_q >> 1);
        n_lim = (NW+QW)'(i_q) << N;
        r_v[0]    = i_valid;
        r_ovx[0]  = (i_q == '0) || (n_nx0 >= n_lim);
        r_ovy[0]  = (i_q == '0) || (n_ny0 >= n_lim);
        r_rx[0]   = NW'(n_nx0);
        r_ry[0]   = NW'(n_ny0);
        r_qx[0]   = '0;
        r_qy[0]   = '0;
        r_d[0]    = i_q;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        localparam int SH = N - 1 - k;
        logic [NW+QW-1:0] n_tx, n_ty, n_dd;
        logic             n_kx, n_ky;
        always_comb begin
            n_dd = (NW+QW)'(r_d[k]) << SH;
            n_tx = (NW+QW)'(r_rx[k]);
            n_ty = (NW+QW)'(r_ry[k]);
            n_kx = n_tx >= n_dd;
            n_ky = n_ty >= n_dd;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else          r_v[k+1] <= r_v[k];
            r_rx[k+1]   <= n_kx ? NW'(n_tx - n_dd) : r_rx[k];
            r_ry[k+1]   <= n_ky ? NW'(n_ty - n_dd) : r_ry[k];
            r_qx[k+1]   <= r_qx[k] | (N'(n_kx) << SH);
            r_qy[k+1]   <= r_qy[k] | (N'(n_ky) << SH);
            r_ovx[k+1]  <= r_ovx[k];
            r_ovy[k+1]  <= r_ovy[k];
            r_d[k+1]    <= r_d[k];
            r_side[k+1] <= r_side[k];
        end
    end

    always_comb begin
        if (r_d[N] == '0) begin
            o_nx = '0;
            o_ny = '0;
        end else begin
            o_nx = (r_ovx[N] || r_qx[N] > N'(ccc_pkg::NORM_ONE)) ?
                   N'(ccc_pkg::NORM_ONE) : r_qx[N];
            o_ny = (r_ovy[N] || r_qy[N] > N'(ccc_pkg::NORM_ONE)) ?
                   N'(ccc_pkg::NORM_ONE) : r_qy[N];
        end
    end
    assign o_valid = r_v[N];
    assign o_q     = r_d[N];
    assign o_side  = r_side[N];
endmodule

>>> design/circle_circle_collision.sv
// Path from start to o_done: stages 1 to 4, the sqrt and divide pipes, stage A and stage B.
// Throughput: one pair per cycle; busy stays low, the sqrt and divide stages are fully pipelined.
// Each result is shown for one cycle with o_done; the receiver cannot stall.
// Reset (synchronous, active low) clears the stage valid bits only.
module circle_circle_collision (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ccc_pkg::t_in  i_in,
    output logic          o_done,
    output ccc_pkg::t_out o_out
);
    localparam int CB = ccc_pkg::COORD_BITS;
    localparam int RB = ccc_pkg::RSUM_BITS;
    localparam int DB = ccc_pkg::D2_BITS;

    assign busy = 1'b0;
    logic w_acc;
    assign w_acc = start && !busy;

    // Stage 1: differences, magnitudes and radius sum.
    logic r_v1;
    logic signed [CB:0] r_dx, r_dy;
    logic [RB-1:0] r_rsum;
    ccc_pkg::t_in r_in1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= w_acc;
        r_dx   <= (CB+1)'(i_in.centre_b_x) - (CB+1)'(i_in.centre_a_x);
        r_dy   <= (CB+1)'(i_in.centre_b_y) - (CB+1)'(i_in.centre_a_y);
        r_rsum <= RB'(i_in.radius_a) + RB'(i_in.radius_b);
        r_in1  <= i_in;
    end
    logic [CB:0] n_adx, n_ady;
    assign n_adx = r_dx[CB] ? (CB+1)'(0) - r_dx : r_dx;
    assign n_ady = r_dy[CB] ? (CB+1)'(0) - r_dy : r_dy;

    // Stage 2: far test and truncated magnitudes.
    logic r_v2, r_far2;
    ccc_pkg::t_side r_s2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_far2     <= (n_adx > (CB+1)'(r_rsum)) || (n_ady > (CB+1)'(r_rsum));
        r_s2.hit   <= 1'b0;
        r_s2.sx    <= r_dx[CB];
        r_s2.sy    <= r_dy[CB];
        r_s2.adx   <= RB'(n_adx);
        r_s2.ady   <= RB'(n_ady);
        r_s2.rsum  <= r_rsum;
        r_s2.ra    <= r_in1.radius_a;
        r_s2.ax    <= r_in1.centre_a_x;
        r_s2.ay    <= r_in1.centre_a_y;
    end

    // Stage 3: squares.
    logic r_v3, r_far3;
    logic [DB-1:0] r_sqx, r_sqy, r_sqr;
    ccc_pkg::t_side r_s3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_far3 <= r_far2;
        r_sqx  <= DB'(r_s2.adx * r_s2.adx);
        r_sqy  <= DB'(r_s2.ady * r_s2.ady);
        r_sqr  <= DB'(r_s2.rsum * r_s2.rsum);
        r_s3   <= r_s2;
    end

    // Stage 4: sum of squares and hit decision.
    logic r_v4;
    logic [DB-1:0] r_d2;
    ccc_pkg::t_side r_s4;
    ccc_pkg::t_side n_s4;
    logic [DB-1:0] n_d2;
    assign n_d2 = r_sqx + r_sqy;
    always_comb begin
        n_s4     = r_s3;
        n_s4.hit = !r_far3 && (n_d2 <= r_sqr);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_d2       <= n_d2;
        r_s4       <= n_s4;
    end

    logic w_v5;
    logic [ccc_pkg::Q_BITS-1:0] w_q5;
    ccc_pkg::t_side w_s5;
    ccc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v4),
        .i_n({r_d2, 28'd0}), .i_side(r_s4),
        .o_valid(w_v5), .o_q(w_q5), .o_side(w_s5)
    );

    logic w_v6;
    logic [ccc_pkg::DIV_BITS-1:0] w_nx, w_ny;
    logic [ccc_pkg::Q_BITS-1:0] w_q6;
    ccc_pkg::t_side w_s6;
    ccc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_v5), .i_q(w_q5), .i_side(w_s5),
        .o_valid(w_v6), .o_nx(w_nx), .o_ny(w_ny), .o_q(w_q6), .o_side(w_s6)
    );

    // Stage A: signed normals, distance rounding, contact offset products.
    localparam int PW = ccc_pkg::DIV_BITS + ccc_pkg::RAD_BITS;
    logic r_va;
    logic signed [ccc_pkg::NORM_BITS-1:0] r_nx, r_ny;
    logic [PW-1:0] r_px, r_py;
    logic [RB-1:0] r_d8;
    ccc_pkg::t_side r_sa;
    logic [ccc_pkg::Q_BITS-1:0] n_d8w;
    assign n_d8w = (w_q6 + ccc_pkg::Q_BITS'(8192)) >> 14;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else          r_va <= w_v6;
        r_nx <= w_s6.sx ? -ccc_pkg::NORM_BITS'(w_nx) : ccc_pkg::NORM_BITS'(w_nx);
        r_ny <= w_s6.sy ? -ccc_pkg::NORM_BITS'(w_ny) : ccc_pkg::NORM_BITS'(w_ny);
        r_px <= PW'(w_nx * w_s6.ra);
        r_py <= PW'(w_ny * w_s6.ra);
        r_d8 <= (n_d8w > ccc_pkg::Q_BITS'(w_s6.rsum)) ? w_s6.rsum : RB'(n_d8w);
        r_sa <= w_s6;
    end

    // Stage B: rounded offsets, add and saturate, gate on hit.
    localparam int OW = PW - 13;
    logic [OW-1:0] n_ox, n_oy;
    logic signed [CB+1:0] n_cx, n_cy, n_lo, n_hi;
    always_comb begin
        n_ox = OW'((r_px + PW'(8192)) >> 14);
        n_oy = OW'((r_py + PW'(8192)) >> 14);
        n_lo = -((CB+2)'(1) <<< (CB-1));
        n_hi = ((CB+2)'(1) <<< (CB-1)) - (CB+2)'(1);
        n_cx = (CB+2)'(r_sa.ax) + (r_sa.sx ? -(CB+2)'(n_ox) : (CB+2)'(n_ox));
        n_cy = (CB+2)'(r_sa.ay) + (r_sa.sy ? -(CB+2)'(n_oy) : (CB+2)'(n_oy));
        if (n_cx < n_lo) n_cx = n_lo;
        if (n_cx > n_hi) n_cx = n_hi;
        if (n_cy < n_lo) n_cy = n_lo;
        if (n_cy > n_hi) n_cy = n_hi;
    end

    logic r_done;
    ccc_pkg::t_out r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_va;
        r_out.hit         <= r_sa.hit;
        r_out.normal_x    <= r_sa.hit ? r_nx : '0;
        r_out.normal_y    <= r_sa.hit ? r_ny : '0;
        r_out.contact_x   <= r_sa.hit ? CB'(n_cx) : '0;
        r_out.contact_y   <= r_sa.hit ? CB'(n_cy) : '0;
        r_out.penetration <= r_sa.hit ? ccc_pkg::PEN_BITS'(r_sa.rsum - r_d8) : '0;
    end
    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_out.hit |-> o_out.normal_x == '0 && o_out.penetration == '0)
        else $error("miss beat carries nonzero fields");
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_out.normal_x <= 16'sd16384 && o_out.normal_x >= -16'sd16384)
        else $error("normal out of range");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_va))
        else $error("done without stage valid");
`endif
endmodule
